// File: rtl/core/assert_macros.svh
// Assertion macros used by the resequencer back end (prs_back).
// Each macro expects clk and arst_n to be visible where it is used.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define CHK_SAME_CYCLE(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define CHK_NEXT_CYCLE(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// File: rtl/core/prs_pkg.sv
package prs_pkg;

	localparam int TAG_BITS = 8;
	localparam int TAG_KEEP = (TAG_BITS < 8) ? TAG_BITS : 8;
	localparam int SLOTS = 256;
	localparam int WIN = 16;
	localparam int WIN_W = $clog2(WIN);

	localparam logic [1:0] FUNC_ARRIVE = 2'd0;
	localparam logic [1:0] FUNC_TICK = 2'd1;
	localparam logic [1:0] FUNC_PULL = 2'd2;

	localparam logic [15:0] GAP_TIMEOUT_RST = 16'd100;

	typedef enum logic [1:0] {
		OP_STORE,
		OP_PASS,
		OP_TICK,
		OP_PULL
	} op_t;

	typedef struct packed {
		op_t op;
		logic [7:0] seq;
		logic [7:0] hdr;
		logic [7:0] len;
		logic [TAG_KEEP-1:0] tag;
	} cmd_t;

	typedef struct packed {
		logic reliable;
		logic [15:0] timeout;
		logic timer_clr;
	} cfg_t;

	typedef struct packed {
		logic [7:0] hdr;
		logic [7:0] len;
		logic [TAG_KEEP-1:0] tag;
	} slot_t;

endpackage

// File: rtl/core/prs_front.sv
module prs_front (
	input logic clk,
	input logic arst_n,
	input logic s_tvalid,
	output logic s_tready,
	input logic [31:0] s_tdata,  // seq, hdr, payload_len, payload_tag
	input logic [1:0] s_tuser,   // func
	input logic reliable,
	output logic cmd_valid,
	input logic cmd_pop,
	output prs_pkg::cmd_t cmd
);
	import prs_pkg::*;

	localparam int DEPTH = 2;
	localparam int PTR_W = $clog2(DEPTH);
	localparam int CNT_W = $clog2(DEPTH + 1);

	cmd_t fifo_q [DEPTH];
	logic [PTR_W-1:0] wr_ptr_q;
	logic [PTR_W-1:0] rd_ptr_q;
	logic [CNT_W-1:0] count_q;
	cmd_t dec;
	logic keep;
	logic push;

	always_comb begin
		dec.seq = s_tdata[7:0];
		dec.hdr = s_tdata[15:8];
		dec.len = s_tdata[23:16];
		dec.tag = s_tdata[24 +: TAG_KEEP];
		keep = 1'b1;
		unique case (s_tuser)
			FUNC_ARRIVE: dec.op = reliable ? OP_STORE : OP_PASS;
			FUNC_TICK: dec.op = OP_TICK;
			FUNC_PULL: dec.op = OP_PULL;
			default: begin
				dec.op = OP_TICK;
				keep = 1'b0;
			end
		endcase
	end

	assign s_tready = count_q != CNT_W'(DEPTH);
	assign push = s_tvalid && s_tready && keep;
	assign cmd_valid = count_q != '0;
	assign cmd = fifo_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push) begin
			fifo_q[wr_ptr_q] <= dec;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= wr_ptr_q + PTR_W'(1);
			end
			if (cmd_pop) begin
				rd_ptr_q <= rd_ptr_q + PTR_W'(1);
			end
			if (push && !cmd_pop) begin
				count_q <= count_q + CNT_W'(1);
			end else if (!push && cmd_pop) begin
				count_q <= count_q - CNT_W'(1);
			end
		end
	end

endmodule

// File: rtl/core/prs_back.sv
`include "assert_macros.svh"

module prs_back (
	input logic clk,
	input logic arst_n,
	input prs_pkg::cfg_t cfg,
	input logic cmd_valid,
	input prs_pkg::cmd_t cmd,
	output logic cmd_pop,
	output logic m_tvalid,
	input logic m_tready,
	output logic [31:0] m_tdata,  // out_seq, out_hdr, out_len, out_tag
	output logic [0:0] m_tuser    // out_valid
);
	import prs_pkg::*;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_SCAN,
		ST_READ,
		ST_NULL
	} state_t;

	state_t state_q;
	logic [SLOTS-1:0] full_q;
	logic [8:0] full_cnt_q;
	logic [7:0] exp_q;
	logic [7:0] base_q;
	logic [7:0] idx_q;
	logic timer_on_q;
	logic [15:0] elapsed_q;
	logic m_tvalid_q;
	logic [31:0] m_tdata_q;
	logic m_tuser_q;

	slot_t mem_q [SLOTS];
	slot_t rd_q;
	logic rd_en;
	logic [7:0] rd_addr;
	logic mem_we;

	logic out_free;
	logic read_done;
	logic out_load;
	logic exp_hit;
	logic store_empty;
	logic [WIN-1:0] win;
	logic hit;
	logic [WIN_W-1:0] off;
	logic [7:0] scan_idx;

	assign out_free = !m_tvalid_q || m_tready;
	assign exp_hit = full_q[exp_q];
	assign store_empty = full_cnt_q == '0;

	always_comb begin
		for (int j = 0; j < WIN; j++) begin
			win[j] = full_q[8'(base_q + 8'(j))];
		end
		off = '0;
		for (int j = WIN - 1; j >= 0; j--) begin
			if (win[j]) begin
				off = WIN_W'(j);
			end
		end
		hit = |win;
		scan_idx = base_q + 8'(off);
	end

	assign cmd_pop = (state_q == ST_IDLE) && cmd_valid && (cmd.op != OP_PASS || out_free);
	assign mem_we = cmd_pop && cmd.op == OP_STORE;
	assign read_done = state_q == ST_READ && out_free;
	assign out_load = (cmd_pop && cmd.op == OP_PASS) || read_done
		|| (state_q == ST_NULL && out_free);

	always_comb begin
		rd_en = 1'b0;
		rd_addr = exp_q;
		if (cmd_pop && cmd.op == OP_PULL && cfg.reliable && exp_hit) begin
			rd_en = 1'b1;
		end else if (state_q == ST_SCAN && hit) begin
			rd_en = 1'b1;
			rd_addr = scan_idx;
		end
	end

	always_ff @(posedge clk) begin
		if (mem_we) begin
			mem_q[cmd.seq] <= '{hdr: cmd.hdr, len: cmd.len, tag: cmd.tag};
		end
		if (rd_en) begin
			rd_q <= mem_q[rd_addr];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			full_q <= '0;
			full_cnt_q <= '0;
			exp_q <= '0;
			base_q <= '0;
			idx_q <= '0;
			timer_on_q <= 1'b0;
			elapsed_q <= '0;
			m_tvalid_q <= 1'b0;
			m_tdata_q <= '0;
			m_tuser_q <= 1'b0;
		end else begin
			if (m_tvalid_q && m_tready && !out_load) begin
				m_tvalid_q <= 1'b0;
			end
			unique case (state_q)
				ST_IDLE: begin
					if (cmd_pop) begin
						unique case (cmd.op)
							OP_STORE: begin
								full_q[cmd.seq] <= 1'b1;
								if (!full_q[cmd.seq]) begin
									full_cnt_q <= full_cnt_q + 9'd1;
								end
							end
							OP_TICK: begin
								if (timer_on_q && elapsed_q != '1) begin
									elapsed_q <= elapsed_q + 16'd1;
								end
							end
							OP_PASS: begin
								m_tvalid_q <= 1'b1;
								m_tuser_q <= 1'b1;
								m_tdata_q <= {8'(cmd.tag), cmd.len, cmd.hdr, cmd.seq};
							end
							OP_PULL: begin
								if (cfg.reliable) begin
									priority if (exp_hit) begin
										idx_q <= exp_q;
										state_q <= ST_READ;
									end else if (store_empty) begin
										timer_on_q <= 1'b0;
										state_q <= ST_NULL;
									end else if (!timer_on_q) begin
										timer_on_q <= 1'b1;
										elapsed_q <= '0;
										state_q <= ST_NULL;
									end else if (elapsed_q < cfg.timeout) begin
										state_q <= ST_NULL;
									end else begin
										base_q <= exp_q + 8'd1;
										state_q <= ST_SCAN;
									end
								end else if (store_empty) begin
									state_q <= ST_NULL;
								end else begin
									base_q <= '0;
									state_q <= ST_SCAN;
								end
							end
							default: begin
							end
						endcase
					end
				end
				ST_SCAN: begin
					if (hit) begin
						idx_q <= scan_idx;
						state_q <= ST_READ;
					end else begin
						base_q <= base_q + 8'(WIN);
					end
				end
				ST_READ: begin
					if (out_free) begin
						m_tvalid_q <= 1'b1;
						m_tuser_q <= 1'b1;
						m_tdata_q <= {8'(rd_q.tag), rd_q.len, rd_q.hdr, idx_q};
						full_q[idx_q] <= 1'b0;
						full_cnt_q <= full_cnt_q - 9'd1;
						if (cfg.reliable) begin
							exp_q <= idx_q + 8'd1;
							timer_on_q <= 1'b0;
						end
						state_q <= ST_IDLE;
					end
				end
				ST_NULL: begin
					if (out_free) begin
						m_tvalid_q <= 1'b1;
						m_tuser_q <= 1'b0;
						m_tdata_q <= '0;
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
			if (cfg.timer_clr && !(cmd_pop && cmd.op == OP_PULL) && state_q != ST_READ) begin
				timer_on_q <= 1'b0;
			end
		end
	end

	assign m_tvalid = m_tvalid_q;
	assign m_tdata = m_tdata_q;
	assign m_tuser = m_tuser_q;

	`CHK_SAME_CYCLE(a_cnt_bound, 1'b1, full_cnt_q <= 9'(SLOTS), "Fill count exceeds the store size.")
	`CHK_SAME_CYCLE(a_empty_map, full_cnt_q == '0, full_q == '0, "Empty count with occupied slots.")
	`CHK_SAME_CYCLE(a_read_full, state_q == ST_READ, full_q[idx_q], "Delivering an empty slot.")
	`CHK_NEXT_CYCLE(a_timer_off, read_done && cfg.reliable, !timer_on_q, "Gap timer left on.")

endmodule

// File: rtl/core/packet_resequencer_with_timeout.sv
// An arrival or tick waits in the command queue and is absorbed when the back end pops it;
// a pull with the expected packet present reads the RAM, then loads the output in ST_READ.
// A pull that skips ahead, or a pass-through pull, scans the 256-entry bitmap
// 16 slots a cycle; no new command is popped until a pull has delivered its transaction.
// Throughput: one arrival or tick per cycle while the back end is idle and its output is free.
// Reset is asynchronous, active low, and empties the store and the command queue at once.
module packet_resequencer_with_timeout (
	input logic clk,
	input logic arst_n,
	input logic s_tvalid,
	output logic s_tready,
	input logic [31:0] s_tdata,  // seq, hdr, payload_len, payload_tag
	input logic [1:0] s_tuser,   // func
	output logic m_tvalid,
	input logic m_tready,
	output logic [31:0] m_tdata, // out_seq, out_hdr, out_len, out_tag
	output logic [0:0] m_tuser,  // out_valid
	input logic psel,
	input logic penable,
	input logic pwrite,
	input logic [2:0] paddr,
	input logic [31:0] pwdata,
	output logic [31:0] prdata,
	output logic pready
);
	import prs_pkg::*;

	localparam logic REG_MODE = 1'b0;
	localparam logic REG_TIMEOUT = 1'b1;

	logic reliable_q;
	logic [15:0] timeout_q;
	logic wr_en;
	cfg_t cfg;
	logic cmd_valid;
	logic cmd_pop;
	cmd_t cmd;

	assign pready = 1'b1;
	assign wr_en = psel && penable && pwrite && pready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			reliable_q <= 1'b1;
			timeout_q <= GAP_TIMEOUT_RST;
		end else if (wr_en) begin
			unique case (paddr[2])
				REG_MODE: reliable_q <= pwdata[0];
				REG_TIMEOUT: timeout_q <= pwdata[15:0];
				default: begin
				end
			endcase
		end
	end

	always_comb begin
		unique case (paddr[2])
			REG_MODE: prdata = {31'd0, reliable_q};
			REG_TIMEOUT: prdata = {16'd0, timeout_q};
			default: prdata = '0;
		endcase
	end

	assign cfg.reliable = reliable_q;
	assign cfg.timeout = timeout_q;
	assign cfg.timer_clr = wr_en && paddr[2] == REG_MODE && !pwdata[0];

	prs_front u_front (
		.clk(clk),
		.arst_n(arst_n),
		.s_tvalid(s_tvalid),
		.s_tready(s_tready),
		.s_tdata(s_tdata),
		.s_tuser(s_tuser),
		.reliable(reliable_q),
		.cmd_valid(cmd_valid),
		.cmd_pop(cmd_pop),
		.cmd(cmd)
	);

	prs_back u_back (
		.clk(clk),
		.arst_n(arst_n),
		.cfg(cfg),
		.cmd_valid(cmd_valid),
		.cmd(cmd),
		.cmd_pop(cmd_pop),
		.m_tvalid(m_tvalid),
		.m_tready(m_tready),
		.m_tdata(m_tdata),
		.m_tuser(m_tuser)
	);

endmodule

// File: dv/tb_packet_resequencer_with_timeout.sv
module tb_packet_resequencer_with_timeout;
	import prs_pkg::*;

	localparam logic [1:0] FUNC_NONE = 2'd3;
	localparam logic [2:0] ADDR_MODE = 3'd0;
	localparam logic [2:0] ADDR_TIMEOUT = 3'd4;
	localparam int WATCHDOG_LIMIT = 4000;
	localparam int SETTLE_CYCLES = 30;
	localparam int RANDOM_ITEMS = 1000;

	typedef struct packed {
		logic valid;
		logic [7:0] tag;
		logic [7:0] len;
		logic [7:0] hdr;
		logic [7:0] seq;
	} delivery_t;

	localparam delivery_t NOTHING = '0;

	typedef enum {ROW_ITEM, ROW_CFG} row_kind_t;

	typedef struct {
		row_kind_t kind;
		logic [1:0] func;
		logic [2:0] addr;
		logic [31:0] word;
		bit typed;
		delivery_t want;
	} step_row_t;

	logic clk;
	logic arst_n;
	logic s_tvalid;
	logic s_tready;
	logic [31:0] s_tdata;
	logic [1:0] s_tuser;
	logic m_tvalid;
	logic m_tready;
	logic [31:0] m_tdata;
	logic [0:0] m_tuser;
	logic psel;
	logic penable;
	logic pwrite;
	logic [2:0] paddr;
	logic [31:0] pwdata;
	logic [31:0] prdata;
	logic pready;

	packet_resequencer_with_timeout dut (
		.clk(clk),
		.arst_n(arst_n),
		.s_tvalid(s_tvalid),
		.s_tready(s_tready),
		.s_tdata(s_tdata),
		.s_tuser(s_tuser),
		.m_tvalid(m_tvalid),
		.m_tready(m_tready),
		.m_tdata(m_tdata),
		.m_tuser(m_tuser),
		.psel(psel),
		.penable(penable),
		.pwrite(pwrite),
		.paddr(paddr),
		.pwdata(pwdata),
		.prdata(prdata),
		.pready(pready)
	);

	bit held_full [256];
	slot_t held_desc [256];
	int held_count;
	logic [7:0] next_seq;
	bit gap_running;
	logic [15:0] gap_ticks;
	bit mode_reorder;
	logic [15:0] gap_limit;

	delivery_t due_deliveries [$];
	int errors;
	int quiet_cycles;
	int burst_left;
	int items_sent;

	step_row_t directed [] = '{
		'{ROW_ITEM, FUNC_PULL, ADDR_MODE, 32'h00000000, 1'b1, NOTHING},
		'{ROW_ITEM, FUNC_ARRIVE, ADDR_MODE, 32'hffffff00, 1'b0, NOTHING},
		'{ROW_ITEM, FUNC_PULL, ADDR_MODE, 32'h00000000, 1'b1, {1'b1, 32'hffffff00}},
		'{ROW_ITEM, FUNC_ARRIVE, ADDR_MODE, 32'h000000ff, 1'b0, NOTHING},
		'{ROW_ITEM, FUNC_PULL, ADDR_MODE, 32'h00000000, 1'b1, NOTHING},
		'{ROW_ITEM, FUNC_TICK, ADDR_MODE, 32'hffffffff, 1'b0, NOTHING},
		'{ROW_ITEM, FUNC_PULL, ADDR_MODE, 32'h00000000, 1'b1, NOTHING},
		'{ROW_CFG, FUNC_NONE, ADDR_TIMEOUT, 32'd1, 1'b0, NOTHING},
		'{ROW_ITEM, FUNC_PULL, ADDR_MODE, 32'h00000000, 1'b1, {1'b1, 32'h000000ff}},
		'{ROW_ITEM, FUNC_ARRIVE, ADDR_MODE, 32'h00a5a500, 1'b0, NOTHING},
		'{ROW_ITEM, FUNC_ARRIVE, ADDR_MODE, 32'hc33c5a00, 1'b0, NOTHING},
		'{ROW_ITEM, FUNC_PULL, ADDR_MODE, 32'h00000000, 1'b1, {1'b1, 32'hc33c5a00}},
		'{ROW_ITEM, FUNC_NONE, ADDR_MODE, 32'h5555aa55, 1'b0, NOTHING},
		'{ROW_ITEM, FUNC_ARRIVE, ADDR_MODE, 32'h56341205, 1'b0, NOTHING},
		'{ROW_ITEM, FUNC_PULL, ADDR_MODE, 32'h00000000, 1'b1, NOTHING},
		'{ROW_CFG, FUNC_NONE, ADDR_TIMEOUT, 32'd0, 1'b0, NOTHING},
		'{ROW_ITEM, FUNC_PULL, ADDR_MODE, 32'h00000000, 1'b1, {1'b1, 32'h56341205}},
		'{ROW_ITEM, FUNC_ARRIVE, ADDR_MODE, 32'h0f0f0f08, 1'b0, NOTHING},
		'{ROW_ITEM, FUNC_PULL, ADDR_MODE, 32'h00000000, 1'b1, NOTHING},
		'{ROW_CFG, FUNC_NONE, ADDR_MODE, 32'd0, 1'b0, NOTHING},
		'{ROW_ITEM, FUNC_ARRIVE, ADDR_MODE, 32'h3322114d, 1'b1, {1'b1, 32'h3322114d}},
		'{ROW_ITEM, FUNC_PULL, ADDR_MODE, 32'h00000000, 1'b0, NOTHING},
		'{ROW_ITEM, FUNC_PULL, ADDR_MODE, 32'h00000000, 1'b1, NOTHING},
		'{ROW_ITEM, FUNC_TICK, ADDR_MODE, 32'h00000000, 1'b0, NOTHING},
		'{ROW_CFG, FUNC_NONE, ADDR_MODE, 32'd1, 1'b0, NOTHING},
		'{ROW_CFG, FUNC_NONE, ADDR_TIMEOUT, 32'd65535, 1'b0, NOTHING},
		'{ROW_ITEM, FUNC_PULL, ADDR_MODE, 32'h00000000, 1'b1, NOTHING}
	};

	function automatic delivery_t release_slot(input logic [7:0] idx);
		delivery_t d;
		d = {1'b1, held_desc[idx].tag, held_desc[idx].len, held_desc[idx].hdr, idx};
		held_full[idx] = 1'b0;
		held_count--;
		return d;
	endfunction

	function automatic bit resequence_step(input logic [1:0] func, input logic [31:0] word,
			output delivery_t d);
		logic [7:0] s;
		logic [7:0] probe;
		int k;
		d = NOTHING;
		s = word[7:0];
		case (func)
			FUNC_ARRIVE: begin
				if (!mode_reorder) begin
					d = {1'b1, word};
					return 1'b1;
				end
				if (!held_full[s])
					held_count++;
				held_full[s] = 1'b1;
				held_desc[s] = '{hdr: word[15:8], len: word[23:16], tag: word[31:24]};
				return 1'b0;
			end
			FUNC_TICK: begin
				if (gap_running && gap_ticks != 16'hffff)
					gap_ticks++;
				return 1'b0;
			end
			FUNC_PULL: begin
				if (!mode_reorder) begin
					for (k = 0; k < 256; k++) begin
						if (held_full[k]) begin
							d = release_slot(8'(k));
							return 1'b1;
						end
					end
					return 1'b1;
				end
				if (!held_full[next_seq]) begin
					if (held_count == 0) begin
						gap_running = 1'b0;
						return 1'b1;
					end
					if (!gap_running) begin
						gap_running = 1'b1;
						gap_ticks = '0;
						return 1'b1;
					end
					if (gap_ticks < gap_limit)
						return 1'b1;
					for (k = 1; k < 256; k++) begin
						probe = next_seq + 8'(k);
						if (held_full[probe]) begin
							next_seq = probe;
							break;
						end
					end
				end
				d = release_slot(next_seq);
				next_seq = next_seq + 8'd1;
				gap_running = 1'b0;
				return 1'b1;
			end
			default: return 1'b0;
		endcase
	endfunction

	task automatic report(input string msg);
		$display("%0t: %s", $time, msg);
		errors++;
	endtask

	task automatic send_item(input logic [1:0] func, input logic [31:0] word, input bit typed,
			input delivery_t want);
		delivery_t d;
		if (burst_left == 0) begin
			s_tvalid <= 1'b0;
			repeat ($urandom_range(1, 8)) @(negedge clk);
			burst_left = ($urandom_range(0, 4) == 0) ? $urandom_range(20, 60) :
				$urandom_range(1, 10);
		end
		s_tvalid <= 1'b1;
		s_tdata <= word;
		s_tuser <= func;
		do @(posedge clk); while (!s_tready);
		if (resequence_step(func, word, d))
			due_deliveries.insert(due_deliveries.size(), typed ? want : d);
		if (func != FUNC_NONE)
			items_sent++;
		burst_left--;
		@(negedge clk);
	endtask

	task automatic settle();
		s_tvalid <= 1'b0;
		while (due_deliveries.size() != 0) @(negedge clk);
		repeat (SETTLE_CYCLES) @(negedge clk);
	endtask

	task automatic apb_write(input logic [2:0] addr, input logic [31:0] data);
		psel <= 1'b1;
		pwrite <= 1'b1;
		paddr <= addr;
		pwdata <= data;
		@(negedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
		if (addr == ADDR_MODE) begin
			mode_reorder = data[0];
			if (!data[0])
				gap_running = 1'b0;
		end else begin
			gap_limit = data[15:0];
		end
		@(negedge clk);
		psel <= 1'b0;
		penable <= 1'b0;
		@(negedge clk);
	endtask

	task automatic send_arrival(input logic [7:0] s);
		send_item(FUNC_ARRIVE, {8'($urandom), 8'($urandom), 8'($urandom), s}, 1'b0, NOTHING);
	endtask

	task automatic send_pull();
		send_item(FUNC_PULL, $urandom, 1'b0, NOTHING);
	endtask

	task automatic send_ticks();
		int n;
		n = ($urandom_range(0, 3) == 0 && gap_limit <= 16'd128) ? int'(gap_limit) + 1 :
			$urandom_range(0, 3);
		repeat (n) send_item(FUNC_TICK, $urandom, 1'b0, NOTHING);
	endtask

	task automatic traffic_window();
		logic [7:0] seqs [12];
		logic [7:0] base;
		logic [7:0] tmp;
		int n;
		int i;
		int j;
		n = $urandom_range(1, 12);
		base = next_seq + (($urandom_range(0, 3) == 0) ? 8'($urandom_range(1, 6)) : 8'd0);
		for (i = 0; i < n; i++)
			seqs[i] = base + 8'(i);
		for (i = n - 1; i > 0; i--) begin
			j = $urandom_range(0, i);
			tmp = seqs[i];
			seqs[i] = seqs[j];
			seqs[j] = tmp;
		end
		for (i = 0; i < n; i++) begin
			if ($urandom_range(0, 5) != 0)
				send_arrival(seqs[i]);
			if ($urandom_range(0, 9) == 0)
				send_arrival(seqs[i]);
			if ($urandom_range(0, 2) == 0)
				send_pull();
			if ($urandom_range(0, 4) == 0)
				send_ticks();
			if ($urandom_range(0, 9) == 0)
				send_item(2'($urandom_range(0, 3)), $urandom, 1'b0, NOTHING);
		end
		repeat ($urandom_range(n, n + 4)) begin
			send_ticks();
			send_pull();
		end
	endtask

	always @(posedge clk) begin
		if ((s_tvalid && s_tready) || (m_tvalid && m_tready))
			quiet_cycles <= 0;
		else
			quiet_cycles <= quiet_cycles + 1;
	end

	always @(posedge clk) begin
		delivery_t e;
		if (arst_n && m_tvalid && m_tready) begin
			if (due_deliveries.size() == 0) begin
				report($sformatf("unexpected transaction seq %h", m_tdata[7:0]));
			end else begin
				e = due_deliveries.pop_front();
				if (m_tuser[0] !== e.valid)
					report($sformatf("out_valid %b, expected %b", m_tuser[0], e.valid));
				if (m_tdata[7:0] !== e.seq)
					report($sformatf("out_seq %h, expected %h", m_tdata[7:0], e.seq));
				if (m_tdata[15:8] !== e.hdr)
					report($sformatf("out_hdr %h, expected %h", m_tdata[15:8], e.hdr));
				if (m_tdata[23:16] !== e.len)
					report($sformatf("out_len %h, expected %h", m_tdata[23:16], e.len));
				if (m_tdata[31:24] !== e.tag)
					report($sformatf("out_tag %h, expected %h", m_tdata[31:24], e.tag));
			end
		end
	end

	initial begin
		clk = 1'b0;
		forever #4 clk = ~clk;
	end

	initial begin
		int mode_left;
		int stall_mode;
		int beat;
		m_tready = 1'b0;
		forever begin
			@(negedge clk);
			if (mode_left == 0) begin
				stall_mode = $urandom_range(0, 3);
				mode_left = $urandom_range(20, 200);
			end
			mode_left--;
			beat++;
			case (stall_mode)
				0: m_tready <= 1'b1;
				1: m_tready <= 1'($urandom_range(0, 1));
				2: m_tready <= ($urandom_range(0, 3) == 0);
				default: m_tready <= (beat % 5 < 2);
			endcase
		end
	end

	initial begin
		while (quiet_cycles < WATCHDOG_LIMIT) @(posedge clk);
		$display("FAIL");
		$finish;
	end

	initial begin
		arst_n = 1'b0;
		s_tvalid = 1'b0;
		s_tdata = '0;
		s_tuser = '0;
		psel = 1'b0;
		penable = 1'b0;
		pwrite = 1'b0;
		paddr = '0;
		pwdata = '0;
		mode_reorder = 1'b1;
		gap_limit = GAP_TIMEOUT_RST;
		next_seq = '0;
		gap_running = 1'b0;
		gap_ticks = '0;
		held_count = 0;
		repeat (7) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		foreach (directed[i]) begin
			if (directed[i].kind == ROW_CFG) begin
				settle();
				apb_write(directed[i].addr, directed[i].word);
			end else begin
				send_item(directed[i].func, directed[i].word, directed[i].typed,
					directed[i].want);
			end
		end

		items_sent = 0;
		while (items_sent < RANDOM_ITEMS) begin
			settle();
			apb_write(ADDR_MODE, ($urandom_range(0, 5) == 0) ? 32'd0 : 32'd1);
			case ($urandom_range(0, 5))
				0: apb_write(ADDR_TIMEOUT, 32'd0);
				1: apb_write(ADDR_TIMEOUT, 32'd1);
				2: apb_write(ADDR_TIMEOUT, 32'($urandom_range(2, 5)));
				3: apb_write(ADDR_TIMEOUT, 32'($urandom_range(0, 16)));
				4: apb_write(ADDR_TIMEOUT, 32'd100);
				default: apb_write(ADDR_TIMEOUT, 32'($urandom_range(0, 65535)));
			endcase
			repeat ($urandom_range(2, 6)) traffic_window();
		end

		s_tvalid <= 1'b0;
		while (due_deliveries.size() != 0) @(negedge clk);
		repeat (SETTLE_CYCLES) @(negedge clk);
		if (errors == 0)
			$display("PASS");
		else
			$display("FAIL");
		$finish;
	end

endmodule
